// ===== rtl/core/cwgc_pkg.sv =====
// Shared types, widths and helpers for the centred-window gain control block.
package cwgc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 32;
	localparam int HW_W     = 6;
	localparam int DAMP_W   = 32;
	localparam int CNT_W    = 7;   // counts, window sizes and flush index
	localparam int ENERGY_W = 37;
	localparam int SQ_W     = 31;
	localparam int DIV_W    = ENERGY_W + 1;
	localparam int NUM_W    = SAMPLE_W + CNT_W + 31;
	localparam int NUM_CW   = $clog2(NUM_W);
	localparam int IDX_W    = 1;

	localparam logic [IDX_W-1:0] REG_HALF_WINDOW = 1'd0;
	localparam logic [IDX_W-1:0] REG_DAMP        = 1'd1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [CNT_W-1:0]           count;
		logic [ENERGY_W-1:0]        energy;
		logic                       last;
		logic                       short_flag;
	} cwgc_job_t;

	localparam int JOB_W = $bits(cwgc_job_t);

	function automatic logic [SQ_W-1:0] sq16(input logic signed [SAMPLE_W-1:0] s);
		logic signed [31:0] p;
		p = s * s;
		return p[SQ_W-1:0];
	endfunction

endpackage

// ===== rtl/core/cwgc_if.sv =====
// Channel interfaces: sample feed, result stream and configuration writes.
interface cwgc_in_if import cwgc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       trace_end;
	modport source (output valid, sample, trace_end, input ready);
	modport sink   (input valid, sample, trace_end, output ready);
endinterface

interface cwgc_out_if import cwgc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [GAIN_W-1:0] gained;
	logic                     last_of_trace;
	logic                     short_trace;
	modport source (output valid, gained, last_of_trace, short_trace, input ready);
	modport sink   (input valid, gained, last_of_trace, short_trace, output ready);
endinterface

interface cwgc_cfg_if import cwgc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [DAMP_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/cwgc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cwgc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end
endmodule

// ===== rtl/core/cwgc_fifo.sv =====
// Short job queue between the front sequencer and the divider.
module cwgc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      fill_q;

	assign full  = (fill_q == (PW+1)'(DEPTH));
	assign empty = (fill_q == '0);
	assign rdata = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			buf_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop && !empty) begin
				rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			fill_q <= fill_q + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
		end
	end
endmodule

// ===== rtl/core/cwgc_front.sv =====
// Front sequencer: delay line, running energy, position count and job issue.
module cwgc_front import cwgc_pkg::*; #(
	parameter int MAX_HALF_WINDOW = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	cwgc_in_if.sink          feed,
	input  logic [HW_W-1:0]  half_window,
	input  logic             hw_write,
	output logic             push,
	output cwgc_job_t        job,
	input  logic             full
);
	localparam int DEPTH = 2 * MAX_HALF_WINDOW;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TW    = PW + CNT_W + 1;
	localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(2 * MAX_HALF_WINDOW + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_UPD   = 3'd1;
	localparam logic [2:0] ST_RDH   = 3'd2;
	localparam logic [2:0] ST_EMIT  = 3'd3;
	localparam logic [2:0] ST_SHORT = 3'd4;
	localparam logic [2:0] ST_FRA   = 3'd5;
	localparam logic [2:0] ST_FSUB  = 3'd6;
	localparam logic [2:0] ST_FPUSH = 3'd7;

	logic [2:0]                 state_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       end_q;
	logic [PW-1:0]              wp_q;
	logic [CNT_W-1:0]           count_q, k_q;
	logic [ENERGY_W-1:0]        energy_q;
	logic [SAMPLE_W-1:0]        rdata_q;
	logic [PW-1:0]              raddr;
	logic [CNT_W-1:0]           h, w2, m;

	function automatic logic [PW-1:0] tap_addr(input logic [PW-1:0] wp,
	                                           input logic [CNT_W-1:0] back);
		logic [TW-1:0] t;
		t = TW'(wp) + TW'(DEPTH - 1) - TW'(back);
		if (t >= TW'(DEPTH)) begin
			t = t - TW'(DEPTH);
		end
		return t[PW-1:0];
	endfunction

	// out-of-range half windows clamp to 1 .. MAX
	always_comb begin
		if (half_window == '0) begin
			h = CNT_W'(1);
		end else if (CNT_W'(half_window) > CNT_W'(MAX_HALF_WINDOW)) begin
			h = CNT_W'(MAX_HALF_WINDOW);
		end else begin
			h = CNT_W'(half_window);
		end
		w2 = h + h;
		m  = (count_q < h + 1'b1) ? count_q : h + 1'b1;
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE:                    raddr = tap_addr(wp_q, w2 - 1'b1);
			ST_RDH, ST_EMIT:            raddr = tap_addr(wp_q, h);
			ST_FRA:                     raddr = tap_addr(wp_q, w2 - 1'b1 - k_q);
			ST_FSUB, ST_FPUSH:          raddr = tap_addr(wp_q, h - 1'b1 - k_q);
			default:                    raddr = wp_q;
		endcase
	end

	cwgc_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_delay (
		.clk     (clk),
		.we      (state_q == ST_UPD),
		.waddr   (wp_q),
		.wdata   (sample_q),
		.raddr   (raddr),
		.rdata_q (rdata_q)
	);

	// no item is taken in the cycle a half-window write resets the trace
	assign feed.ready = (state_q == ST_IDLE) && !hw_write;

	always_comb begin
		push            = 1'b0;
		job.sample      = $signed(rdata_q);
		job.count       = (count_q < w2) ? count_q : w2;
		job.energy      = energy_q;
		job.last        = 1'b0;
		job.short_flag  = 1'b0;
		unique case (state_q)
			ST_EMIT: begin
				push = !(end_q && count_q < w2) && (count_q > h);
			end
			ST_SHORT: begin
				push           = 1'b1;
				job.short_flag = 1'b1;
				job.last       = (k_q + 1'b1 == m);
			end
			ST_FPUSH: begin
				push      = 1'b1;
				job.count = w2 - 1'b1 - k_q;
				job.last  = (k_q + 1'b1 == h);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (feed.valid && feed.ready) begin
			sample_q <= feed.sample;
			end_q    <= feed.trace_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wp_q     <= '0;
			count_q  <= '0;
			k_q      <= '0;
			energy_q <= '0;
		end else if (hw_write) begin
			count_q  <= '0;
			energy_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (feed.valid) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					energy_q <= energy_q
						- ((count_q >= w2) ? ENERGY_W'(sq16($signed(rdata_q))) : '0)
						+ ENERGY_W'(sq16(sample_q));
					wp_q     <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
					if (count_q < COUNT_CAP) begin
						count_q <= count_q + 1'b1;
					end
					state_q  <= ST_RDH;
				end
				ST_RDH: state_q <= ST_EMIT;
				ST_EMIT: begin
					k_q <= '0;
					if (end_q && count_q < w2) begin
						state_q <= ST_SHORT;
					end else if (!(push && full)) begin
						state_q <= end_q ? ST_FRA : ST_IDLE;
					end
				end
				ST_SHORT: begin
					if (!full) begin
						if (job.last) begin
							count_q  <= '0;
							energy_q <= '0;
							state_q  <= ST_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_FRA: state_q <= ST_FSUB;
				ST_FSUB: begin
					energy_q <= energy_q - ENERGY_W'(sq16($signed(rdata_q)));
					state_q  <= ST_FPUSH;
				end
				ST_FPUSH: begin
					if (!full) begin
						if (job.last) begin
							count_q  <= '0;
							energy_q <= '0;
							state_q  <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_FRA;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/cwgc_back.sv =====
// Back end: restoring divider, saturation and the result register.
module cwgc_back import cwgc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cwgc_job_t         job,
	input  logic              empty,
	output logic              pop,
	input  logic [DAMP_W-1:0] damp,
	cwgc_out_if.source        result
);
	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_DIV  = 2'd1;
	localparam logic [1:0] B_SAT  = 2'd2;
	localparam logic [1:0] B_OUT  = 2'd3;

	logic [1:0]              state_q;
	logic [NUM_W-1:0]        num_q;
	logic [DIV_W-1:0]        rem_q, d_q, d;
	logic [NUM_CW-1:0]       cnt_q;
	logic                    neg_q, last_q, short_q;
	logic signed [GAIN_W-1:0] gained_q;
	logic [SAMPLE_W-1:0]     mag;
	logic [SAMPLE_W+CNT_W-1:0] prod;
	logic [DIV_W:0]          trial;

	assign d     = DIV_W'(job.energy) + DIV_W'(damp);
	assign mag   = job.sample[SAMPLE_W-1] ? SAMPLE_W'(-job.sample) : SAMPLE_W'(job.sample);
	assign prod  = mag * job.count;
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign pop   = (state_q == B_IDLE) && !empty;

	assign result.valid         = (state_q == B_OUT);
	assign result.gained        = gained_q;
	assign result.last_of_trace = last_q;
	assign result.short_trace   = short_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						neg_q   <= job.sample[SAMPLE_W-1];
						last_q  <= job.last;
						short_q <= job.short_flag;
						num_q   <= {prod, 31'd0};
						rem_q   <= '0;
						d_q     <= d;
						cnt_q   <= '0;
						if (job.short_flag || d == '0) begin
							gained_q <= '0;
							state_q  <= B_OUT;
						end else begin
							state_q <= B_DIV;
						end
					end
				end
				B_DIV: begin
					// one quotient bit a cycle, shifted into num_q
					if (trial >= {1'b0, d_q}) begin
						rem_q <= DIV_W'(trial - {1'b0, d_q});
						num_q <= {num_q[NUM_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[DIV_W-1:0];
						num_q <= {num_q[NUM_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == NUM_CW'(NUM_W - 1)) begin
						state_q <= B_SAT;
					end
				end
				B_SAT: begin
					if (neg_q) begin
						gained_q <= (num_q >= NUM_W'(64'h8000_0000)) ? 32'sh8000_0000
						          : -$signed(num_q[GAIN_W-1:0]);
					end else begin
						gained_q <= (num_q > NUM_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
						          : $signed(num_q[GAIN_W-1:0]);
					end
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (result.ready) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/centered_window_gain_control.sv =====
// Top level of the centred-window gain control: config registers, front, queue, back.
//
//   channel  role   handshake       payload
//   feed     sink   valid / ready   sample[15:0] signed, trace_end
//   result   source valid / ready   gained[31:0] signed, last_of_trace, short_trace
//   cfg      sink   valid / ready   index (0 half_window, 1 damp), data[31:0]
//
// Front: each item passes the delay-line RAM in order (read old tap, update,
// read centre tap, issue); each flush result takes two more RAM reads.
// Back: a result with a divisor runs through the 54-bit restoring divider
// (one quotient bit a cycle); short or zero-divisor results skip it with zero gain.
// Reset clears counts, energy, pointers and queue; the delay line is not cleared.
// A four-entry job queue lets the front run ahead while the divider or the
// result sink stalls; cfg is always ready.
module centered_window_gain_control import cwgc_pkg::*; #(
	parameter int MAX_HALF_WINDOW = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	cwgc_in_if.sink    feed,
	cwgc_out_if.source result,
	cwgc_cfg_if.sink   cfg
);
	logic [HW_W-1:0]   half_window_q;
	logic [DAMP_W-1:0] damp_q;
	logic              hw_write;
	logic              push, pop, full, empty;
	cwgc_job_t         job_in, job_out;

	assign cfg.ready = 1'b1;
	assign hw_write  = cfg.valid && (cfg.index == REG_HALF_WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_window_q <= HW_W'(16);
			damp_q        <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_HALF_WINDOW: half_window_q <= cfg.data[HW_W-1:0];
				REG_DAMP:        damp_q        <= cfg.data;
				default: ;
			endcase
		end
	end

	cwgc_front #(.MAX_HALF_WINDOW(MAX_HALF_WINDOW)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.feed        (feed),
		.half_window (half_window_q),
		.hw_write    (hw_write),
		.push        (push),
		.job         (job_in),
		.full        (full)
	);

	cwgc_fifo #(.WIDTH(JOB_W), .DEPTH(4)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.pop    (pop),
		.rdata  (job_out),
		.full   (full),
		.empty  (empty)
	);

	cwgc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job_out),
		.empty  (empty),
		.pop    (pop),
		.damp   (damp_q),
		.result (result)
	);

	// a short-trace result always carries zero gain
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.short_trace |-> result.gained == '0)
		else $error("short-trace result with nonzero gain");

	// popping only a non-empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job popped from empty queue");

	// a taken feed item always leaves the front busy next cycle
	a_feed_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		feed.valid && feed.ready |=> !feed.ready)
		else $error("front accepted two items back to back");
endmodule

// ===== test/centered_window_gain_control_test.sv =====
// Self-checking testbench for the centred-window gain control block.
`timescale 1ns / 1ps

module centered_window_gain_control_test;
	import cwgc_pkg::*;

	localparam int MAX_HW      = 32;
	localparam int DELAY_DEPTH = 2 * MAX_HW;
	localparam int COUNT_CAP   = 2 * MAX_HW + 1;
	localparam int RANDOM_ITEMS = 175;
	// Front and divider latency with queue backlog, plus margin for stalls.
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic signed [GAIN_W-1:0] gained;
		logic                     last_of_trace;
		logic                     short_trace;
	} gain_result_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       trace_end;
	} sample_item_t;

	logic clk;
	logic arst_n;

	cwgc_in_if  feed ();
	cwgc_out_if result ();
	cwgc_cfg_if cfg ();

	centered_window_gain_control #(.MAX_HALF_WINDOW(MAX_HW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.result (result),
		.cfg    (cfg)
	);

	// Predictor state: a private copy of the delay line, energy and registers.
	logic signed [SAMPLE_W-1:0] trace_history [DELAY_DEPTH];
	longint unsigned            run_energy;
	int                         samples_seen;
	int                         history_ptr;
	logic [HW_W-1:0]            half_window_reg;
	logic [DAMP_W-1:0]          damp_reg;

	gain_result_t expected_gains [$];
	sample_item_t pending_samples [$];

	int  mismatches;
	int  items_pushed;
	int  items_taken;
	int  results_checked;
	int  traces_sent;
	int  short_traces;
	int  random_items;
	bit  calm;          // no idling on either side once set
	bit  item_taken;    // feed handshake at the last rising edge
	int  feed_gap;
	int  sink_gap;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Generous guard: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int active_half();
		if (half_window_reg == 0) return 1;
		if (half_window_reg > MAX_HW) return MAX_HW;
		return int'(half_window_reg);
	endfunction

	// Sample received 'back' items before the newest one.
	function automatic longint history_tap(int back);
		return longint'(trace_history[(history_ptr + DELAY_DEPTH - 1 - (back % DELAY_DEPTH))
			% DELAY_DEPTH]);
	endfunction

	function automatic longint unsigned energy_of(longint s);
		return longint'(s * s);
	endfunction

	// sample * n * 2^31 / (energy + damp), truncated toward zero, saturated.
	function automatic logic signed [GAIN_W-1:0] window_gain(longint s, int n);
		longint unsigned divisor;
		longint unsigned mag;
		longint unsigned quot;
		divisor = run_energy + longint'(damp_reg);
		if (divisor == 0) return '0;
		mag  = (s < 0) ? longint'(-s) : longint'(s);
		quot = ((mag * longint'(n)) << 31) / divisor;
		if (s < 0) begin
			if (quot >= 64'h8000_0000) return 32'sh8000_0000;
			return -$signed(quot[31:0]);
		end
		if (quot > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
		return $signed(quot[31:0]);
	endfunction

	function automatic void expect_gain(logic signed [GAIN_W-1:0] g, bit last, bit short_f);
		gain_result_t r;
		r.gained        = g;
		r.last_of_trace = last;
		r.short_trace   = short_f;
		expected_gains.push_back(r);
	endfunction

	// Work out every result that one accepted sample releases.
	function automatic void predict_sample(logic signed [SAMPLE_W-1:0] s, logic trace_end);
		int h;
		int span;
		int flushes;
		int nw;
		h    = active_half();
		span = 2 * h;
		if (samples_seen >= span)
			run_energy -= energy_of(history_tap(span - 1));
		trace_history[history_ptr] = s;
		history_ptr = (history_ptr + 1) % DELAY_DEPTH;
		run_energy += energy_of(longint'(s));
		if (samples_seen < COUNT_CAP) samples_seen++;

		// Trace too short for a full window: remaining results are flagged, gain zero.
		if (trace_end && samples_seen < span) begin
			flushes = (samples_seen < h + 1) ? samples_seen : h + 1;
			for (int k = 0; k < flushes; k++)
				expect_gain('0, k + 1 == flushes, 1'b1);
			run_energy   = 0;
			samples_seen = 0;
			return;
		end

		if (samples_seen > h) begin
			nw = (samples_seen < span) ? samples_seen : span;
			expect_gain(window_gain(history_tap(h), nw), 1'b0, 1'b0);
		end

		// Normal end: the window shrinks from the far side for each flushed result.
		if (trace_end) begin
			for (int k = 0; k < h; k++) begin
				run_energy -= energy_of(history_tap(span - 1 - k));
				expect_gain(window_gain(history_tap(h - 1 - k), span - 1 - k), k + 1 == h, 1'b0);
			end
			run_energy   = 0;
			samples_seen = 0;
		end
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d (result %0d)",
			$realtime, what, got, want, results_checked);
		mismatches++;
	endtask

	// Monitor: every handshake is observed at the rising edge.
	always @(posedge clk) begin
		gain_result_t want;
		item_taken = 1'b0;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (expected_gains.size() == 0) begin
					report_mismatch("unexpected result, gained", result.gained, 0);
				end else begin
					want = expected_gains.pop_front();
					if (result.gained !== want.gained)
						report_mismatch("gained", result.gained, want.gained);
					if (result.last_of_trace !== want.last_of_trace)
						report_mismatch("last_of_trace", result.last_of_trace, want.last_of_trace);
					if (result.short_trace !== want.short_trace)
						report_mismatch("short_trace", result.short_trace, want.short_trace);
				end
				results_checked++;
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_HALF_WINDOW) begin
					// New half window abandons whatever trace was in flight.
					half_window_reg = cfg.data[HW_W-1:0];
					run_energy      = 0;
					samples_seen    = 0;
				end else if (cfg.index == REG_DAMP) begin
					damp_reg = cfg.data;
				end
			end
			if (feed.valid && feed.ready) begin
				predict_sample(feed.sample, feed.trace_end);
				item_taken = 1'b1;
				items_taken++;
			end
		end
	end

	// Sample driver: holds an item until taken, idles in random bursts.
	always @(negedge clk) begin
		sample_item_t it;
		if (arst_n && (!feed.valid || item_taken)) begin
			if (feed_gap > 0) begin
				feed_gap--;
				feed.valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				feed_gap = $urandom_range(0, 18);
				feed.valid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				it = pending_samples.pop_front();
				feed.valid     <= 1'b1;
				feed.sample    <= it.sample;
				feed.trace_end <= it.trace_end;
			end else begin
				feed.valid <= 1'b0;
			end
		end
	end

	// Result sink: ready with random stall bursts.
	always @(negedge clk) begin
		if (arst_n) begin
			if (sink_gap > 0) begin
				sink_gap--;
				result.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(0, 18);
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	task automatic push_sample(int s, bit trace_end);
		sample_item_t it;
		it.sample    = s[SAMPLE_W-1:0];
		it.trace_end = trace_end;
		pending_samples.push_back(it);
		items_pushed++;
	endtask

	task automatic write_register(logic [IDX_W-1:0] idx, logic [DAMP_W-1:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Wait until every item is taken and every result is in, then let the
	// block finish any item that produced nothing.
	task automatic settle();
		while (items_taken != items_pushed || expected_gains.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_sample(int style);
		case (style)
			0: return $urandom_range(0, 65535) - 32768;
			1: return $urandom_range(0, 8) - 4;      // tiny values drive saturation
			default: begin
				case ($urandom_range(0, 3))
					0: return -32768;
					1: return 32767;
					2: return 0;
					default: return -1;
				endcase
			end
		endcase
	endfunction

	// A trace with random content; no end marker when abandoned.
	task automatic push_trace(int len, bit abandoned);
		int style;
		style = $urandom_range(0, 9);
		style = (style < 6) ? 0 : (style < 8) ? 1 : 2;
		for (int i = 0; i < len; i++) begin
			if (style == 0 && $urandom_range(0, 9) == 0)
				push_sample(pick_sample(2), !abandoned && i == len - 1);
			else
				push_sample(pick_sample(style), !abandoned && i == len - 1);
			random_items++;
		end
		if (!abandoned) traces_sent++;
	endtask

	initial begin
		int h;
		int len;
		int ntraces;
		int pick;
		logic [DAMP_W-1:0] damp_val;

		mismatches = 0; items_pushed = 0; items_taken = 0; results_checked = 0;
		traces_sent = 0; short_traces = 0; random_items = 0;
		calm = 1'b0; item_taken = 1'b0; feed_gap = 0; sink_gap = 0;
		run_energy = 0; samples_seen = 0; history_ptr = 0;
		half_window_reg = HW_W'(16); damp_reg = '0;
		foreach (trace_history[i]) trace_history[i] = '0;

		feed.valid = 1'b0; feed.sample = '0; feed.trace_end = 1'b0;
		result.ready = 1'b0;
		cfg.valid = 1'b0; cfg.index = REG_HALF_WINDOW; cfg.data = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: half window 2, no damping.
		write_register(REG_HALF_WINDOW, 32'd2);
		write_register(REG_DAMP, 32'd0);
		push_sample(32767, 0); push_sample(-32768, 0); push_sample(0, 0);
		push_sample(1, 0); push_sample(-1, 1);           // extremes and saturation
		push_sample(5, 1);                              // one-sample short trace
		push_sample(-32768, 0); push_sample(32767, 0); push_sample(-1, 1); // short of three
		push_sample(0, 0); push_sample(0, 0); push_sample(0, 0); push_sample(0, 1); // zero divisor
		traces_sent += 4; short_traces += 2;
		settle();

		// Half window zero acts as one; negative full-scale pair.
		write_register(REG_HALF_WINDOW, 32'd0);
		push_sample(-32768, 0); push_sample(-32768, 1);
		traces_sent++;
		settle();

		// Trace abandoned by a half-window write mid-stream.
		push_sample(1, 0); push_sample(0, 0); push_sample(-32768, 0);
		settle();
		write_register(REG_HALF_WINDOW, 32'd1);
		write_register(REG_DAMP, 32'hFFFF_FFFF);
		push_sample(32767, 0); push_sample(1, 1);
		traces_sent++;
		settle();

		// Out-of-range half window clamps to the maximum; short trace there.
		write_register(REG_HALF_WINDOW, 32'd63);
		push_sample(32767, 0); push_sample(-32768, 0); push_sample(7, 1);
		traces_sent++; short_traces++;
		settle();

		// Random phases: each picks a setting, then feeds a few traces.
		while (random_items < RANDOM_ITEMS) begin
			if (random_items > RANDOM_ITEMS * 4 / 5) calm = 1'b1;
			pick = $urandom_range(0, 19);
			case (pick)
				0:       h = 0;
				1:       h = $urandom_range(33, 63);
				2:       h = 32;
				3, 4, 5: h = 1;
				default: h = $urandom_range(2, 6);
			endcase
			case ($urandom_range(0, 4))
				0:       damp_val = '0;
				1:       damp_val = 32'hFFFF_FFFF;
				2:       damp_val = $urandom_range(0, 255);
				default: damp_val = $urandom();
			endcase
			write_register(REG_HALF_WINDOW, h);
			write_register(REG_DAMP, damp_val);
			h = (h == 0) ? 1 : (h > MAX_HW) ? MAX_HW : h;
			ntraces = (h >= 16) ? 1 : $urandom_range(1, 3);
			for (int t = 0; t < ntraces; t++) begin
				pick = $urandom_range(0, 19);
				if (pick < 3) begin
					len = $urandom_range(1, 2 * h - 1);
					short_traces++;
					push_trace(len, 0);
				end else if (pick == 3 && t == ntraces - 1) begin
					push_trace($urandom_range(1, 2 * h + 2), 1);
				end else begin
					push_trace($urandom_range(2 * h, 3 * h + 3), 0);
				end
			end
			settle();
		end

		$display("covered %0d items in %0d ended traces (%0d short), %0d results checked",
			items_taken, traces_sent, short_traces, results_checked);
		$display("half windows 0..63 including clamped values, damp from zero to all ones");
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== centered_window_gain_control.f =====
rtl/core/cwgc_pkg.sv
rtl/core/cwgc_if.sv
rtl/core/cwgc_ram.sv
rtl/core/cwgc_fifo.sv
rtl/core/cwgc_front.sv
rtl/core/cwgc_back.sv
rtl/core/centered_window_gain_control.sv
test/centered_window_gain_control_test.sv
